// ----- rtl/core/brb_pkg.sv -----
// shared types, constants and a pointer helper for the byte ring buffer
package brb_pkg;

  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(DEPTH + 1);

  // fixed field widths of the channel payloads
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 12;
  localparam int CNT_W  = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_CONSUME = 2'd3
  } brb_cmd_t;

  // memory request issued in the cycle an item is taken
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } brb_ram_req_t;

  // everything of a result except the byte that comes back from memory
  typedef struct packed {
    logic             use_rd;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] level;
    logic             is_empty;
    logic             is_full;
  } brb_meta_t;

  // index below DEPTH plus a distance of at most DEPTH, modulo DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [LVL_W-1:0]  b);
    logic [LVL_W:0] s;
    s = (LVL_W + 1)'(a) + (LVL_W + 1)'(b);
    if (s >= (LVL_W + 1)'(DEPTH)) begin
      s = s - (LVL_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/brb_in_if.sv -----
// command channel: valid/ready plus one command item
interface brb_in_if
  import brb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_in;
  logic [OFF_W-1:0]  offset;
  logic [CNT_W-1:0]  count;

  modport source (output valid, cmd, data_in, offset, count, input ready);
  modport sink   (input valid, cmd, data_in, offset, count, output ready);
endinterface

// ----- rtl/core/brb_out_if.sv -----
// result channel: valid/ready plus one result item
interface brb_out_if
  import brb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic [CNT_W-1:0]  moved;
  logic [CNT_W-1:0]  level;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, data_out, moved, level, is_empty, is_full, input ready);
  modport sink   (input valid, data_out, moved, level, is_empty, is_full, output ready);
endinterface

// ----- rtl/core/brb_ram.sv -----
// generic single write port, single read port ram with registered read
module brb_ram #(
  parameter int DATA_W     = 8,
  parameter int ADDR_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(ADDR_DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]             wdata,
  input  logic                          re,
  input  logic [$clog2(ADDR_DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]             rdata
);

  logic [DATA_W-1:0] mem [ADDR_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/brb_ctrl.sv -----
// head and fill pointers, command decode and memory request
module brb_ctrl
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [BYTE_W-1:0] data_in,
  input  logic [OFF_W-1:0]  offset,
  input  logic [CNT_W-1:0]  count,
  output brb_ram_req_t      ram_req,
  output brb_meta_t         meta
);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [LVL_W-1:0]  fill_r, fill_nxt;
  logic [LVL_W-1:0]  skip;
  logic [LVL_W-1:0]  moved;
  logic              use_rd;
  brb_ram_req_t      req;

  // consume saturates at the fill level
  assign skip = (LVL_W'(count) < fill_r) ? LVL_W'(count) : fill_r;

  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    moved     = '0;
    use_rd    = 1'b0;
    req       = '0;
    req.wdata = data_in;
    req.waddr = wrap_add(head_r, fill_r);
    req.raddr = head_r;
    unique case (brb_cmd_t'(cmd))
      CMD_WRITE: begin
        if (fill_r < LVL_W'(DEPTH)) begin
          req.we   = 1'b1;
          fill_nxt = fill_r + LVL_W'(1);
          moved    = LVL_W'(1);
        end
      end
      CMD_READ: begin
        if (fill_r != '0) begin
          req.re   = 1'b1;
          use_rd   = 1'b1;
          head_nxt = wrap_add(head_r, LVL_W'(1));
          fill_nxt = fill_r - LVL_W'(1);
          moved    = LVL_W'(1);
        end
      end
      CMD_PEEK: begin
        req.raddr = wrap_add(head_r, LVL_W'(offset));
        if (LVL_W'(offset) < fill_r) begin
          req.re = 1'b1;
          use_rd = 1'b1;
          moved  = LVL_W'(1);
        end
      end
      CMD_CONSUME: begin
        head_nxt = wrap_add(head_r, skip);
        fill_nxt = fill_r - skip;
        moved    = skip;
      end
      default: begin
        head_nxt = head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign ram_req.we    = req.we & accept;
  assign ram_req.re    = req.re & accept;
  assign ram_req.waddr = req.waddr;
  assign ram_req.wdata = req.wdata;
  assign ram_req.raddr = req.raddr;

  assign meta.use_rd   = use_rd;
  assign meta.moved    = CNT_W'(moved);
  assign meta.level    = CNT_W'(fill_nxt);
  assign meta.is_empty = (fill_nxt == '0);
  assign meta.is_full  = (fill_nxt == LVL_W'(DEPTH));

endmodule

// ----- rtl/core/brb_out_reg.sv -----
// stage that waits for memory data, then the result output register
module brb_out_reg
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  brb_meta_t         meta_in,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              stage_open,
  output logic              stage_busy,
  brb_out_if.source         out_ch
);

  logic              s1_v_r, s1_v_nxt;
  brb_meta_t         s1_meta_r;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_data_r;
  brb_meta_t         out_meta_r;
  logic              advance;

  assign advance    = s1_v_r & (~out_v_r | out_ch.ready);
  assign stage_open = ~s1_v_r | advance;
  assign stage_busy = s1_v_r;

  always_comb begin
    s1_v_nxt  = load | (s1_v_r & ~advance);
    out_v_nxt = advance | (out_v_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // memory data is held by the ram while this stage waits
  always_ff @(posedge clk) begin
    if (load) begin
      s1_meta_r <= meta_in;
    end
    if (advance) begin
      out_meta_r <= s1_meta_r;
      out_data_r <= s1_meta_r.use_rd ? rd_data : '0;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.moved    = out_meta_r.moved;
  assign out_ch.level    = out_meta_r.level;
  assign out_ch.is_empty = out_meta_r.is_empty;
  assign out_ch.is_full  = out_meta_r.is_full;

endmodule

// ----- rtl/core/byte_ring_buffer_peek_consume.sv -----
// top level of the circular byte buffer with write, read, peek and consume
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    cmd, data_in, offset, count
//  out_ch   out  valid / ready    data_out, moved, level, is_empty, is_full
//
// one command per cycle is taken while in_ch.ready is high; its result passes through the wait
// stage that covers the registered read port of the byte memory, then the output register
// reset clears the head and fill pointers and the stage valid flags; memory contents are not cleared
// a stalled result holds in the output register while one more command waits behind it
// in_ch.ready drops only when both of those places are full
module byte_ring_buffer_peek_consume
  import brb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  brb_in_if.sink     in_ch,
  brb_out_if.source  out_ch
);

  logic              accept;
  logic              stage_open;
  logic              stage_busy;
  brb_ram_req_t      ram_req;
  brb_meta_t         meta;
  logic [BYTE_W-1:0] rd_data;

  // a transfer on the command channel
  assign in_ch.ready = stage_open;
  assign accept      = in_ch.valid & stage_open;

  // pointer state and command decode, all settled in the cycle of the transfer
  brb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (in_ch.cmd),
    .data_in (in_ch.data_in),
    .offset  (in_ch.offset),
    .count   (in_ch.count),
    .ram_req (ram_req),
    .meta    (meta)
  );

  // byte store, write and read never fall in the same cycle
  brb_ram #(
    .DATA_W     (BYTE_W),
    .ADDR_DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // joins memory data with the result fields and drives the result channel
  brb_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .meta_in    (meta),
    .rd_data    (rd_data),
    .stage_open (stage_open),
    .stage_busy (stage_busy),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // at most one memory access per command
  a_one_ram_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("write and read issued together");

  // a byte is returned only when exactly one byte moved
  a_rd_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept && meta.use_rd |-> meta.moved == CNT_W'(1))
    else $error("read data selected on a refused command");

  // a taken command always lands in the wait stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> stage_busy)
    else $error("accepted command lost");

  // fill level never exceeds capacity
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> meta.level <= CNT_W'(DEPTH))
    else $error("fill level beyond capacity");
`endif

endmodule
